[rtl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int ELEM_W = 16;
    localparam int D_W    = 17;
    localparam int QB     = 17;
    localparam int NSLOT  = 4;

    localparam logic [QB-1:0] POS_LIM = 17'd32767;
    localparam logic [QB-1:0] NEG_LIM = 17'd32768;

    typedef enum logic [1:0] {SLOT_W, SLOT_X, SLOT_Y, SLOT_Z} slot_t;

    typedef struct packed {
        logic                        bad;
        slot_t                       main;
        logic [NSLOT-1:0]            neg;
        logic [NSLOT-1:0][D_W-1:0]   mag;
        logic [ELEM_W-1:0]           main_val;
        logic                        main_ovf;
    } side_t;

endpackage

[rtl/rotation_matrix_to_quaternion_unit.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a 3x3 rotation matrix to a unit quaternion, fully pipelined.
// ----------------------------------------------------------------------------
// channel   ports                          handshake
// matrix    m00 .. m22                     start, accepted when busy is low
// quat      qw qx qy qz degenerate         done, one cycle, no hold-off
//
// One word enters per cycle; busy stays low. With RW = root width, the
// pipeline holds one input stage, RW square-root stages, one scaling stage,
// one divider setup stage, 17 quotient stages and one output stage.
// Reset clears only the valid bits; results never stall.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] m00,
    input  logic signed [15:0] m01,
    input  logic signed [15:0] m02,
    input  logic signed [15:0] m10,
    input  logic signed [15:0] m11,
    input  logic signed [15:0] m12,
    input  logic signed [15:0] m20,
    input  logic signed [15:0] m21,
    input  logic signed [15:0] m22,
    output logic               done,
    output logic signed [15:0] qw,
    output logic signed [15:0] qx,
    output logic signed [15:0] qy,
    output logic signed [15:0] qz,
    output logic               degenerate
);

    localparam int F  = FRAC_BITS;
    localparam int AW = (F + 2 > 19) ? F + 2 : 19;
    localparam int RW = (AW + F) / 2;
    localparam int VW = 2 * RW;
    localparam int DW = RW + 1;
    localparam int XW = D_W + F + 1;
    localparam int CW = (RW + 1 > 17) ? RW + 1 : 17;
    localparam logic [AW-1:0] ONE = {{(AW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

    assign busy = 1'b0;

    logic signed [17:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [17:0] trace;
    logic signed [17:0] d [NSLOT];
    logic signed [AW-1:0] arg;
    slot_t              main_sel;
    side_t              a_side_next;
    logic [VW-1:0]      a_v_next;

    assign e00 = 18'(m00);
    assign e01 = 18'(m01);
    assign e02 = 18'(m02);
    assign e10 = 18'(m10);
    assign e11 = 18'(m11);
    assign e12 = 18'(m12);
    assign e20 = 18'(m20);
    assign e21 = 18'(m21);
    assign e22 = 18'(m22);
    assign trace = e00 + e11 + e22;

    always_comb
    begin
        for (int l = 0; l < NSLOT; l++)
        begin
            d[l] = '0;
        end
        priority if (trace > 0)
        begin
            main_sel = SLOT_W;
            arg      = AW'(trace) + signed'(ONE);
            d[1]     = e21 - e12;
            d[2]     = e02 - e20;
            d[3]     = e10 - e01;
        end
        else if (e22 > e00 && e22 > e11)
        begin
            main_sel = SLOT_Z;
            arg      = AW'(e22) - AW'(e00) - AW'(e11) + signed'(ONE);
            d[0]     = e10 - e01;
            d[1]     = e02 + e20;
            d[2]     = e12 + e21;
        end
        else if (e11 > e00)
        begin
            main_sel = SLOT_Y;
            arg      = AW'(e11) - AW'(e22) - AW'(e00) + signed'(ONE);
            d[0]     = e02 - e20;
            d[3]     = e21 + e12;
            d[1]     = e01 + e10;
        end
        else
        begin
            main_sel = SLOT_X;
            arg      = AW'(e00) - AW'(e11) - AW'(e22) + signed'(ONE);
            d[0]     = e21 - e12;
            d[2]     = e10 + e01;
            d[3]     = e20 + e02;
        end
    end

    always_comb
    begin
        logic [17:0] mg;
        a_side_next          = '0;
        a_side_next.main     = main_sel;
        a_side_next.bad      = (arg <= 0);
        for (int l = 0; l < NSLOT; l++)
        begin
            mg                     = d[l][17] ? 18'(-d[l]) : 18'(d[l]);
            a_side_next.neg[l]     = d[l][17];
            a_side_next.mag[l]     = mg[D_W-1:0];
        end
        a_v_next = a_side_next.bad ? '0 : VW'({arg[AW-2:0], {F{1'b0}}});
    end

    logic          a_valid_reg;
    logic [VW-1:0] a_v_reg;
    side_t         a_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_v_reg    <= a_v_next;
        a_side_reg <= a_side_next;
    end

    logic          s_valid;
    logic [RW-1:0] s_root;
    side_t         s_side;

    rmq_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_v      (a_v_reg),
        .in_side   (a_side_reg),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_side  (s_side)
    );

    logic                     p_valid_reg;
    logic [NSLOT-1:0][XW-1:0] p_x_reg;
    logic [DW-1:0]            p_den_reg;
    side_t                    p_side_reg;
    logic [NSLOT-1:0][XW-1:0] p_x_next;
    side_t                    p_side_next;

    always_comb
    begin
        logic [RW:0]   rp1;
        logic [CW-1:0] half;
        rp1  = {1'b0, s_root} + (RW+1)'(1);
        half = CW'(rp1[RW:1]);
        p_side_next = s_side;
        p_side_next.main_ovf = (half > CW'(32767));
        p_side_next.main_val = p_side_next.main_ovf ? 16'sd32767 : half[ELEM_W-1:0];
        for (int l = 0; l < NSLOT; l++)
        begin
            p_x_next[l] = XW'({s_side.mag[l], {F{1'b0}}}) + XW'(s_root);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_x_reg    <= p_x_next;
        p_den_reg  <= {s_root, 1'b0};
        p_side_reg <= p_side_next;
    end

    logic                     v_valid;
    logic [NSLOT-1:0][QB-1:0] v_q;
    logic [NSLOT-1:0]         v_big;
    side_t                    v_side;

    rmq_div #(
        .DW (DW),
        .XW (XW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid_reg),
        .in_x      (p_x_reg),
        .in_den    (p_den_reg),
        .in_side   (p_side_reg),
        .out_valid (v_valid),
        .out_q     (v_q),
        .out_big   (v_big),
        .out_side  (v_side)
    );

    logic [NSLOT-1:0][ELEM_W-1:0] q_next;
    logic                         degen_next;

    always_comb
    begin
        logic sat;
        degen_next = v_side.bad;
        for (int l = 0; l < NSLOT; l++)
        begin
            sat = 1'b0;
            if (v_side.bad)
            begin
                q_next[l] = '0;
            end
            else if (slot_t'(l) == v_side.main)
            begin
                q_next[l] = v_side.main_val;
                sat       = v_side.main_ovf;
            end
            else if (v_side.neg[l])
            begin
                sat       = v_big[l] || (v_q[l] > NEG_LIM);
                q_next[l] = sat ? 16'h8000 : ELEM_W'(-v_q[l]);
            end
            else
            begin
                sat       = v_big[l] || (v_q[l] > POS_LIM);
                q_next[l] = sat ? 16'h7fff : v_q[l][ELEM_W-1:0];
            end
            degen_next = degen_next | sat;
        end
    end

    logic                         done_reg;
    logic [NSLOT-1:0][ELEM_W-1:0] q_reg;
    logic                         degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg     <= q_next;
        degen_reg <= degen_next;
    end

    assign done       = done_reg;
    assign qw         = q_reg[SLOT_W];
    assign qx         = q_reg[SLOT_X];
    assign qy         = q_reg[SLOT_Y];
    assign qz         = q_reg[SLOT_Z];
    assign degenerate = degen_reg;

endmodule

[rtl/rmq_sqrt.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int RW = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [2*RW-1:0] in_v,
    input  side_t           in_side,
    output logic            out_valid,
    output logic [RW-1:0]   out_root,
    output side_t           out_side
);

    localparam int VW = 2 * RW;

    logic [RW+1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [VW-1:0] v_reg    [RW];
    side_t         side_reg [RW];
    logic [RW-1:0] valid_reg;

    genvar s;
    generate
        for (s = 0; s < RW; s++)
        begin : g_stage
            logic [RW+1:0] rem_cur;
            logic [RW-1:0] root_cur;
            logic [VW-1:0] v_cur;
            side_t         side_cur;
            logic          valid_cur;
            logic [RW+1:0] rx;
            logic [RW+1:0] trial;
            logic [RW+1:0] rem_next;
            logic [RW-1:0] root_next;
            logic [VW-1:0] v_next;
            logic          ge;

            if (s == 0)
            begin : g_first
                assign rem_cur   = '0;
                assign root_cur  = '0;
                assign v_cur     = in_v;
                assign side_cur  = in_side;
                assign valid_cur = in_valid;
            end
            else
            begin : g_rest
                assign rem_cur   = rem_reg[s-1];
                assign root_cur  = root_reg[s-1];
                assign v_cur     = v_reg[s-1];
                assign side_cur  = side_reg[s-1];
                assign valid_cur = valid_reg[s-1];
            end

            assign rx        = {rem_cur[RW-1:0], v_cur[VW-1:VW-2]};
            assign trial     = {root_cur, 2'b01};
            assign ge        = (rx >= trial);
            assign rem_next  = ge ? (rx - trial) : rx;
            assign root_next = {root_cur[RW-2:0], ge};
            assign v_next    = {v_cur[VW-3:0], 2'b00};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else
                begin
                    valid_reg[s] <= valid_cur;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                v_reg[s]    <= v_next;
                side_reg[s] <= side_cur;
            end
        end
    endgenerate

    assign out_valid = valid_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

[rtl/rmq_div.sv]
// ----------------------------------------------------------------------------
// rmq_div
// Four-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
#(
    parameter int DW = 17,
    parameter int XW = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [NSLOT-1:0][XW-1:0]  in_x,
    input  logic [DW-1:0]             in_den,
    input  side_t                     in_side,
    output logic                      out_valid,
    output logic [NSLOT-1:0][QB-1:0]  out_q,
    output logic [NSLOT-1:0]          out_big,
    output side_t                     out_side
);

    logic [NSLOT-1:0][DW-1:0] r0_reg;
    logic [NSLOT-1:0][QB-1:0] xl0_reg;
    logic [NSLOT-1:0]         big0_reg;
    logic [DW-1:0]            den0_reg;
    side_t                    side0_reg;
    logic                     valid0_reg;

    logic [NSLOT-1:0][DW-1:0] r_reg    [QB];
    logic [NSLOT-1:0][QB-1:0] q_reg    [QB];
    logic [NSLOT-1:0][QB-1:0] xl_reg   [QB];
    logic [NSLOT-1:0]         big_reg  [QB];
    logic [DW-1:0]            den_reg  [QB];
    side_t                    side_reg [QB];
    logic [QB-1:0]            valid_reg;

    logic [NSLOT-1:0][DW-1:0] r0_next;
    logic [NSLOT-1:0]         big0_next;

    always_comb
    begin
        for (int l = 0; l < NSLOT; l++)
        begin
            big0_next[l] = ((in_x[l] >> QB) >= XW'(in_den));
            r0_next[l]   = DW'(in_x[l] >> QB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NSLOT; l++)
        begin
            r0_reg[l]  <= r0_next[l];
            xl0_reg[l] <= in_x[l][QB-1:0];
        end
        big0_reg  <= big0_next;
        den0_reg  <= in_den;
        side0_reg <= in_side;
    end

    genvar s;
    generate
        for (s = 0; s < QB; s++)
        begin : g_stage
            logic [NSLOT-1:0][DW-1:0] r_cur;
            logic [NSLOT-1:0][QB-1:0] q_cur;
            logic [NSLOT-1:0][QB-1:0] xl_cur;
            logic [NSLOT-1:0]         big_cur;
            logic [DW-1:0]            den_cur;
            side_t                    side_cur;
            logic                     valid_cur;
            logic [NSLOT-1:0][DW-1:0] r_next;
            logic [NSLOT-1:0][QB-1:0] q_next;
            logic [NSLOT-1:0][QB-1:0] xl_next;

            if (s == 0)
            begin : g_first
                assign r_cur     = r0_reg;
                assign q_cur     = '0;
                assign xl_cur    = xl0_reg;
                assign big_cur   = big0_reg;
                assign den_cur   = den0_reg;
                assign side_cur  = side0_reg;
                assign valid_cur = valid0_reg;
            end
            else
            begin : g_rest
                assign r_cur     = r_reg[s-1];
                assign q_cur     = q_reg[s-1];
                assign xl_cur    = xl_reg[s-1];
                assign big_cur   = big_reg[s-1];
                assign den_cur   = den_reg[s-1];
                assign side_cur  = side_reg[s-1];
                assign valid_cur = valid_reg[s-1];
            end

            always_comb
            begin
                logic [DW:0] rs;
                logic        ge;
                for (int l = 0; l < NSLOT; l++)
                begin
                    rs         = {r_cur[l], xl_cur[l][QB-1]};
                    ge         = (rs >= {1'b0, den_cur});
                    r_next[l]  = ge ? DW'(rs - {1'b0, den_cur}) : rs[DW-1:0];
                    q_next[l]  = {q_cur[l][QB-2:0], ge};
                    xl_next[l] = {xl_cur[l][QB-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else
                begin
                    valid_reg[s] <= valid_cur;
                end
            end

            always_ff @(posedge clk)
            begin
                r_reg[s]    <= r_next;
                q_reg[s]    <= q_next;
                xl_reg[s]   <= xl_next;
                big_reg[s]  <= big_cur;
                den_reg[s]  <= den_cur;
                side_reg[s] <= side_cur;
            end
        end
    endgenerate

    assign out_valid = valid_reg[QB-1];
    assign out_q     = q_reg[QB-1];
    assign out_big   = big_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule

[rtl/rmq_checker.sv]
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks of the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
module rmq_checker
#(
    parameter int FRAC_BITS = 14
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] qw,
    input logic signed [15:0] qx,
    input logic signed [15:0] qy,
    input logic signed [15:0] qz,
    input logic               degenerate
);

    localparam int AW  = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
    localparam int RW  = (AW + FRAC_BITS) / 2;
    localparam int LAT = RW + 21;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && rst_n, LAT))
        else $error("done does not follow start by the pipeline latency");

    a_zero_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (done && qw == 16'sd0 && qx == 16'sd0 && qy == 16'sd0 && qz == 16'sd0)
        |-> degenerate)
        else $error("all-zero word without degenerate flag");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .qw         (qw),
    .qx         (qx),
    .qy         (qy),
    .qz         (qz),
    .degenerate (degenerate)
);

[bench/rotation_matrix_to_quaternion_unit_tb.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_tb
// Streams matrices with random gaps, predicts each quaternion and compares it
// field by field with the word the unit returns.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_tb;

    localparam int FRAC     = 14;
    localparam int N_RAND   = 1850;
    localparam int WD_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] e [9];
    } matrix_t;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               dg;
    } quat_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic               done;
    logic signed [15:0] qw, qx, qy, qz;
    logic               degenerate;

    matrix_t pending_mats [$];
    quat_t   expected_quats [$];
    int      gap_left;
    int      errors;
    int      idle_cycles;
    bit      feeding_done;

    rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22),
        .done(done), .qw(qw), .qx(qx), .qy(qy), .qz(qz), .degenerate(degenerate)
    );

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_div(longint num, longint unsigned den);
        bit neg;
        longint unsigned mag;
        longint unsigned q;
        neg = num < 0;
        mag = neg ? longint'(-num) : num;
        mag <<= FRAC;
        q = (mag + den / 2) / den;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [15:0] clamp16(longint v, inout logic dg);
        if (v > 32767)
        begin
            dg = 1'b1;
            return 16'sd32767;
        end
        if (v < -32768)
        begin
            dg = 1'b1;
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    function automatic quat_t predict_quat(matrix_t mt);
        longint m [3][3];
        longint q [4];
        longint tr, arg;
        longint unsigned root, den;
        logic dg;
        int i, j, k;
        quat_t r;
        for (int a = 0; a < 9; a++)
            m[a / 3][a % 3] = longint'(mt.e[a]);
        q = '{0, 0, 0, 0};
        dg = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            arg = tr + (64'sd1 << FRAC);
            root = int_sqrt(arg << FRAC);
            den = 2 * root;
            q[0] = (root + 1) >> 1;
            if (den != 0)
            begin
                q[1] = round_div(m[2][1] - m[1][2], den);
                q[2] = round_div(m[0][2] - m[2][0], den);
                q[3] = round_div(m[1][0] - m[0][1], den);
            end
        end
        else
        begin
            i = 0;
            if (m[1][1] > m[0][0])
                i = 1;
            if (m[2][2] > m[i][i])
                i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            arg = m[i][i] - m[j][j] - m[k][k] + (64'sd1 << FRAC);
            if (arg <= 0)
                dg = 1'b1;
            else
            begin
                root = int_sqrt(arg << FRAC);
                den = 2 * root;
                q[1 + i] = (root + 1) >> 1;
                if (den != 0)
                begin
                    q[0] = round_div(m[k][j] - m[j][k], den);
                    q[1 + j] = round_div(m[j][i] + m[i][j], den);
                    q[1 + k] = round_div(m[k][i] + m[i][k], den);
                end
                else
                    dg = 1'b1;
            end
        end
        r.w = clamp16(q[0], dg);
        r.x = clamp16(q[1], dg);
        r.y = clamp16(q[2], dg);
        r.z = clamp16(q[3], dg);
        r.dg = dg;
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'sd0;
            3: return 16'($urandom_range(0, 16384));
            default: return 16'($urandom());
        endcase
    endfunction

    // rotation about a random axis through a random angle, plus perturbation
    function automatic matrix_t rand_rotation();
        real a, b, c, n, th, cs, sn, t;
        real r [9];
        matrix_t mt;
        a = $urandom_range(0, 2000) - 1000.0;
        b = $urandom_range(0, 2000) - 1000.0;
        c = $urandom_range(0, 2000) - 1000.0;
        n = $sqrt(a * a + b * b + c * c) + 1e-9;
        a /= n; b /= n; c /= n;
        th = $urandom_range(0, 6283) / 1000.0;
        cs = $cos(th); sn = $sin(th); t = 1.0 - cs;
        r = '{t*a*a+cs, t*a*b-sn*c, t*a*c+sn*b,
              t*a*b+sn*c, t*b*b+cs, t*b*c-sn*a,
              t*a*c-sn*b, t*b*c+sn*a, t*c*c+cs};
        for (int e = 0; e < 9; e++)
            mt.e[e] = 16'($rtoi(r[e] * 16384.0) + $signed($urandom_range(0, 8)) - 4);
        return mt;
    endfunction

    function automatic matrix_t diag_mat(int d0, int d1, int d2, int off);
        matrix_t mt;
        for (int e = 0; e < 9; e++)
            mt.e[e] = 16'(off);
        mt.e[0] = 16'(d0);
        mt.e[4] = 16'(d1);
        mt.e[8] = 16'(d2);
        return mt;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        matrix_t mt;
        rst_n = 1'b0;
        feeding_done = 1'b0;
        pending_mats.push_back(diag_mat(16384, 16384, 16384, 0));
        pending_mats.push_back(diag_mat(32767, 32767, 32767, 32767));
        pending_mats.push_back(diag_mat(-32768, -32768, -32768, -32768));
        pending_mats.push_back(diag_mat(0, 0, 0, 0));
        pending_mats.push_back(diag_mat(16384, -16384, -16384, 0));
        pending_mats.push_back(diag_mat(-16384, 16384, -16384, 0));
        pending_mats.push_back(diag_mat(-16384, -16384, 16384, 0));
        pending_mats.push_back(diag_mat(-32768, -32768, 32767, 32767));
        pending_mats.push_back(diag_mat(-32768, 32767, 32767, -32768));
        pending_mats.push_back(diag_mat(100, 100, 100, 5));
        pending_mats.push_back(diag_mat(-100, -100, -100, 7));
        pending_mats.push_back(diag_mat(-20000, -20000, -20000, 300));
        pending_mats.push_back(diag_mat(1, 0, -1, 32767));
        pending_mats.push_back(diag_mat(-1, -1, -1, -32768));
        pending_mats.push_back(diag_mat(0, 0, 1, 20000));
        pending_mats.push_back(diag_mat(-16384, 0, 0, 0));
        pending_mats.push_back(diag_mat(-16383, -16384, -16384, 0));
        pending_mats.push_back(diag_mat(32767, -32768, -32768, -32768));
        for (int n = 0; n < N_RAND; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                for (int e = 0; e < 9; e++)
                    mt.e[e] = rand_elem();
            else
                mt = rand_rotation();
            pending_mats.push_back(mt);
        end
        feeding_done = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
            {m00, m01, m02, m10, m11, m12, m20, m21, m22} <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_quats.push_back(predict_quat('{e: '{m00, m01, m02, m10,
                    m11, m12, m20, m21, m22}}));
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_mats.size() > 0)
            begin
                matrix_t nx;
                nx = pending_mats.pop_front();
                {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
                    {nx.e[0], nx.e[1], nx.e[2], nx.e[3], nx.e[4],
                     nx.e[5], nx.e[6], nx.e[7], nx.e[8]};
                start <= 1'b1;
                gap_left <= pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_quats.size() == 0)
            begin
                $error("unexpected word: qw=%0d qx=%0d qy=%0d qz=%0d", qw, qx, qy, qz);
                errors++;
            end
            else
            begin
                quat_t ex;
                ex = expected_quats.pop_front();
                if (qw !== ex.w)
                begin
                    $error("qw: expected %0d, got %0d", ex.w, qw);
                    errors++;
                end
                if (qx !== ex.x)
                begin
                    $error("qx: expected %0d, got %0d", ex.x, qx);
                    errors++;
                end
                if (qy !== ex.y)
                begin
                    $error("qy: expected %0d, got %0d", ex.y, qy);
                    errors++;
                end
                if (qz !== ex.z)
                begin
                    $error("qz: expected %0d, got %0d", ex.z, qz);
                    errors++;
                end
                if (degenerate !== ex.dg)
                begin
                    $error("degenerate: expected %0d, got %0d", ex.dg, degenerate);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", WD_LIMIT);
                $display("rotation_matrix_to_quaternion_unit_tb: done, errors");
                $finish;
            end
            if (feeding_done && pending_mats.size() == 0 && !start
                && expected_quats.size() == 0)
            begin
                repeat (100) @(posedge clk);
                if (expected_quats.size() != 0)
                    errors++;
                if (errors == 0)
                    $display("rotation_matrix_to_quaternion_unit_tb: done, clean");
                else
                    $display("rotation_matrix_to_quaternion_unit_tb: done, errors");
                $finish;
            end
        end
    end

endmodule

[sim.f]
rtl/rmq_pkg.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion_unit.sv
rtl/rmq_checker.sv
bench/rotation_matrix_to_quaternion_unit_tb.sv
